// ===== hdl/ppt_pkg.sv =====
// Package for the pending probe table: command and result types, codes and defaults.
package ppt_pkg;

  localparam int unsigned PPT_MAX_PENDING = 16;
  localparam logic [15:0] PPT_PERIOD_RESET = 16'd1000;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_SWEEP  = 2'd1;
  localparam logic [1:0] KIND_FIND   = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  localparam logic [2:0] STATUS_ADDED     = 3'd0;
  localparam logic [2:0] STATUS_REFRESHED = 3'd1;
  localparam logic [2:0] STATUS_FULL      = 3'd2;
  localparam logic [2:0] STATUS_REJECTED  = 3'd3;
  localparam logic [2:0] STATUS_FOUND     = 3'd4;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd5;
  localparam logic [2:0] STATUS_REMOVED   = 3'd6;
  localparam logic [2:0] STATUS_SWEPT     = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  source_id;
    logic [7:0]  target_id;
    logic        source_named;
    logic        target_named;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] entry_count;
    logic [4:0] expired_count;
  } result_t;

endpackage

// ===== hdl/pending_probe_table.sv =====
// Pending probe table: ordered, compacted table of (source, target, deadline) entries.
//
// Channel   Direction  Handshake                  Payload
// command   in         start & !busy              cmd    (ppt_pkg::cmd_t)
// result    out        done, one cycle, no stall  result (ppt_pkg::result_t)
// config    in         cfg_valid & cfg_ready      cfg_data (period_ms, 16 bits)
//
// From its transfer to the done strobe, a command visits S_READ and S_EVAL for each of
// the N entries held when it arrives, then S_READ and S_APPEND; the compaction pass reads
// each entry from the table memory in two steps (address, then registered read data).
// Busy falls in the cycle that done is high, so the next command can transfer then.
// Reset is synchronous and active high; it empties the table and restores the period
// to 1000 ms. The table memory itself is not cleared, since only slots below the
// entry count are ever read. The receiver cannot stall results; config is always ready.
module pending_probe_table #(
  parameter int unsigned MAX_PENDING = ppt_pkg::PPT_MAX_PENDING
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ppt_pkg::cmd_t    cmd,
  output logic             done,
  output ppt_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);
  import ppt_pkg::*;

  localparam int unsigned IDXW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
  localparam int unsigned CNTW = $clog2(MAX_PENDING + 1);
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_PENDING);

  typedef struct packed {
    logic [7:0]  source;
    logic [7:0]  target;
    logic [31:0] deadline;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_EVAL   = 4'b0100,
    S_APPEND = 4'b1000
  } state_t;

  state_t          state;
  cmd_t            cur;
  logic [15:0]     period;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] rd_ptr;
  logic [CNTW-1:0] wr_ptr;
  logic [CNTW-1:0] expired;
  logic            found;

  // Table memory: one write and one registered read per cycle.
  entry_t          mem [MAX_PENDING];
  entry_t          rd_data;
  logic            rd_en;
  logic [IDXW-1:0] rd_addr;
  logic            wr_en;
  logic [IDXW-1:0] wr_addr;
  entry_t          wr_data;

  // Per-entry decision during the pass: a pair match, or an expired deadline on a sweep.
  logic            pair_hit;
  logic            drop;
  logic            can_append;
  logic [32:0]     deadline_sum;
  logic [31:0]     deadline_new;
  logic [CNTW-1:0] count_next;
  logic [2:0]      status_next;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign pair_hit = (rd_data.source == cur.source_id) && (rd_data.target == cur.target_id);
  assign drop     = (cur.kind == KIND_SWEEP) ? (rd_data.deadline < cur.now_ms) : pair_hit;

  assign deadline_sum = {1'b0, cur.now_ms} + {17'd0, period};
  assign deadline_new = deadline_sum[32] ? 32'hFFFF_FFFF : deadline_sum[31:0];

  assign can_append = (cur.kind == KIND_ADD) && cur.source_named && cur.target_named &&
                      (wr_ptr < CNT_MAX);

  assign rd_en   = (state == S_READ) && (rd_ptr != count);
  assign rd_addr = rd_ptr[IDXW-1:0];

  // Survivors and an added entry are written at wr_ptr, which never passes rd_ptr.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_ptr[IDXW-1:0];
    wr_data = rd_data;
    if (state == S_EVAL) begin
      wr_en = !drop && (cur.kind != KIND_FIND);
    end else if (state == S_APPEND) begin
      wr_en   = can_append;
      wr_data = '{source: cur.source_id, target: cur.target_id, deadline: deadline_new};
    end
  end

  always_comb begin
    count_next  = wr_ptr;
    status_next = STATUS_NOT_FOUND;
    case (cur.kind)
      KIND_ADD: begin
        if (!(cur.source_named && cur.target_named)) begin
          status_next = STATUS_REJECTED;
        end else if (can_append) begin
          count_next  = wr_ptr + CNTW'(1);
          status_next = found ? STATUS_REFRESHED : STATUS_ADDED;
        end else begin
          status_next = STATUS_FULL;
        end
      end
      KIND_SWEEP: begin
        status_next = STATUS_SWEPT;
      end
      KIND_FIND: begin
        count_next  = count;
        status_next = found ? STATUS_FOUND : STATUS_NOT_FOUND;
      end
      KIND_REMOVE: begin
        status_next = found ? STATUS_REMOVED : STATUS_NOT_FOUND;
      end
      default: begin
        status_next = STATUS_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      period  <= PPT_PERIOD_RESET;
      count   <= '0;
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      expired <= '0;
      found   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        period <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur     <= cmd;
            rd_ptr  <= '0;
            wr_ptr  <= '0;
            expired <= '0;
            found   <= 1'b0;
            state   <= S_READ;
          end
        end
        S_READ: begin
          state <= (rd_ptr == count) ? S_APPEND : S_EVAL;
        end
        S_EVAL: begin
          if (drop) begin
            if (cur.kind == KIND_SWEEP) begin
              expired <= expired + CNTW'(1);
            end else begin
              found <= 1'b1;
            end
          end else begin
            wr_ptr <= wr_ptr + CNTW'(1);
          end
          rd_ptr <= rd_ptr + CNTW'(1);
          state  <= S_READ;
        end
        S_APPEND: begin
          count                <= count_next;
          result.status        <= status_next;
          result.entry_count   <= 5'(count_next);
          result.expired_count <= 5'(expired);
          done                 <= 1'b1;
          state                <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a command transfer");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done strobe while still busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("entry count above table depth");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (wr_ptr <= rd_ptr) && (rd_ptr < count))
    else $error("compaction pointers out of order");

  a_expired_sweep_only: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != STATUS_SWEPT)) |-> (result.expired_count == 5'd0))
    else $error("expired count nonzero outside a sweep");
`endif

endmodule
